[rtl/crf_pkg.sv]
package crf_pkg;

    localparam int NODE_INDEX_BITS = 16;

    typedef enum logic [1:0] {
        KIND_ACQUIRE    = 2'd0,
        KIND_REPLY      = 2'd1,
        KIND_INVALIDATE = 2'd2,
        KIND_PURGE      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_REQ      = 2'd1,
        ST_REQ_KILL = 2'd2,
        ST_VALID    = 2'd3
    } copy_state_t;

    typedef enum logic [3:0] {
        ACT_NONE         = 4'd0,
        ACT_SELF_SERVE   = 4'd1,
        ACT_PARK         = 4'd2,
        ACT_SEND         = 4'd3,
        ACT_DROP         = 4'd4,
        ACT_PUBLISH      = 4'd5,
        ACT_PUBLISH_KILL = 4'd6,
        ACT_PURGE_ACK    = 4'd7,
        ACT_KILL_MARKED  = 4'd8,
        ACT_NOOP_ACK     = 4'd9
    } action_t;

    typedef struct packed {
        kind_t                      kind;
        logic [NODE_INDEX_BITS-1:0] node_index;
    } crf_req_t;

    typedef struct packed {
        action_t                    action;
        copy_state_t                copy_state;
        logic                       fetch_open;
        logic [NODE_INDEX_BITS-1:0] chain_head;
    } crf_rsp_t;

    typedef struct packed {
        copy_state_t                copy_state;
        logic                       fetch_open;
        logic [NODE_INDEX_BITS-1:0] chain_head;
    } crf_state_t;

endpackage

[rtl/crf_step.sv]
module crf_step
    import crf_pkg::*;
(
    input  crf_req_t   req,
    input  crf_state_t cur,
    output crf_rsp_t   rsp
);

    always_comb
    begin
        rsp.action     = ACT_NONE;
        rsp.copy_state = cur.copy_state;
        rsp.fetch_open = cur.fetch_open;
        rsp.chain_head = cur.chain_head;

        unique case (req.kind)
            KIND_ACQUIRE:
            begin
                priority if (cur.copy_state == ST_VALID)
                begin
                    rsp.action = ACT_SELF_SERVE;
                end
                else if (cur.fetch_open)
                begin
                    // park behind the open fetch
                    rsp.action     = ACT_PARK;
                    rsp.chain_head = req.node_index;
                end
                else
                begin
                    rsp.action     = ACT_SEND;
                    rsp.copy_state = ST_REQ;
                    rsp.fetch_open = 1'b1;
                    rsp.chain_head = req.node_index;
                end
            end
            KIND_REPLY:
            begin
                if (!cur.fetch_open)
                begin
                    // stale reply: drop
                    rsp.action = ACT_DROP;
                end
                else
                begin
                    rsp.action     = (cur.copy_state == ST_REQ_KILL) ? ACT_PUBLISH_KILL
                                                                     : ACT_PUBLISH;
                    rsp.copy_state = ST_VALID;
                    rsp.fetch_open = 1'b0;
                    rsp.chain_head = '0;
                end
            end
            KIND_INVALIDATE:
            begin
                priority if (cur.copy_state == ST_VALID)
                begin
                    rsp.action     = ACT_PURGE_ACK;
                    rsp.copy_state = ST_IDLE;
                end
                else if (cur.copy_state == ST_REQ)
                begin
                    rsp.action     = ACT_KILL_MARKED;
                    rsp.copy_state = ST_REQ_KILL;
                end
                else
                begin
                    rsp.action = ACT_NOOP_ACK;
                end
            end
            KIND_PURGE:
            begin
                rsp.action     = ACT_NONE;
                rsp.copy_state = ST_IDLE;
            end
            default:
            begin
                rsp.action = ACT_NONE;
            end
        endcase
    end

endmodule

[rtl/coherence_reader_copy_fsm.sv]
// Reader-side coherence machine for one cached copy.
// Request channel (req_valid, req_stall, req): one event per request,
// kind plus the requester's node index.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one response per
// request, giving the action to take and the new copy state, fetch flag
// and chain head.
// Timing: a request accepted into the input register has its response
// loaded into the output register when it advances, and the response is
// offered from then on until it is taken.
// Throughput: one request per cycle while the receiver does not stall.
// The copy state, fetch flag and chain head are updated in the same edge
// that loads the response, so the next request sees them straight away.
// Reset clears the copy to idle, the fetch flag and the chain head to
// zero, and empties both registers.
// When the receiver stalls, the response holds; the input register then
// holds its request and req_stall rises until the response is taken.
module coherence_reader_copy_fsm
    import crf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  crf_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output crf_rsp_t rsp
);

    logic       in_valid_reg, in_valid_next;
    crf_req_t   in_req_reg;
    logic       rsp_valid_reg, rsp_valid_next;
    crf_rsp_t   rsp_reg;
    crf_state_t state_reg;
    crf_rsp_t   step_rsp;
    logic       advance;
    logic       take;

    crf_step u_step (
        .req (in_req_reg),
        .cur (state_reg),
        .rsp (step_rsp)
    );

    // advance the held request once the output register is free
    assign advance   = in_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign take      = req_valid && !req_stall;

    always_comb
    begin
        in_valid_next  = take || (in_valid_reg && !advance);
        rsp_valid_next = advance || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= '{copy_state: ST_IDLE, fetch_open: 1'b0, chain_head: '0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                state_reg.copy_state <= step_rsp.copy_state;
                state_reg.fetch_open <= step_rsp.fetch_open;
                state_reg.chain_head <= step_rsp.chain_head;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= step_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    a_state_tracks_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (state_reg.copy_state == rsp_reg.copy_state)
                 && (state_reg.fetch_open == rsp_reg.fetch_open)
                 && (state_reg.chain_head == rsp_reg.chain_head))
        else $error("state registers disagree with last response");

    a_requested_has_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.copy_state == ST_REQ || state_reg.copy_state == ST_REQ_KILL)
            |-> state_reg.fetch_open)
        else $error("requested copy without an open fetch");

    a_publish_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.action == ACT_PUBLISH
                        || rsp_reg.action == ACT_PUBLISH_KILL))
            |-> (rsp_reg.copy_state == ST_VALID) && !rsp_reg.fetch_open)
        else $error("publish left the fetch open or copy not valid");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> in_valid_reg && rsp_valid_reg && rsp_stall)
        else $error("request stalled with room to advance");
`endif

endmodule
